// ===== hdl/hkf_pkg.sv =====
package hkf_pkg;

  // Key FIFO geometry; one slot is always kept free, so at most FIFO_DEPTH-1 entries
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int KEY_SLOTS  = 6;
  localparam int KEY_CNT_W  = 3;
  localparam int CMP_W      = (PTR_W > KEY_CNT_W) ? PTR_W : KEY_CNT_W;

  localparam logic [7:0] CODE_BACKSPACE = 8'h2A;
  localparam int         SHIFT_LEFT_BIT  = 1;
  localparam int         SHIFT_RIGHT_BIT = 5;

  typedef enum logic [2:0] {
    CMD_REPORT    = 3'd0,
    CMD_POP_RAW   = 3'd1,
    CMD_POP_ASCII = 3'd2,
    CMD_FLUSH     = 3'd3,
    CMD_QUERY     = 3'd4
  } cmd_t;

  typedef logic [KEY_SLOTS-1:0][7:0] key_row_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] modifiers;
    logic [7:0] key_a;
    logic [7:0] key_b;
    logic [7:0] key_c;
    logic [7:0] key_d;
    logic [7:0] key_e;
    logic [7:0] key_f;
    logic [7:0] query_key;
  } hkf_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] fifo_count;
    logic       shift_held;
    logic [2:0] dropped;
  } hkf_rsp_t;

  // Control into the key FIFO for one step
  typedef struct packed {
    logic [KEY_SLOTS-1:0] push_mask;
    logic                 pop;
    logic                 flush;
  } hkf_fifo_ctl_t;

  // Status back from the key FIFO
  typedef struct packed {
    logic [7:0]           pop_code;
    logic [PTR_W-1:0]     fill_next;
    logic [KEY_CNT_W-1:0] dropped;
  } hkf_fifo_sts_t;

  // Entries between read and write pointer on the ring
  function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
                                               input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] t;
    t = {1'b0, wp} + (PTR_W+1)'(FIFO_DEPTH) - {1'b0, rp};
    if (wp >= rp) begin
      return wp - rp;
    end
    return t[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // UK keymap ROM; codes of 128 and above and unlisted codes give 0
  function automatic logic [7:0] map_code(input logic [7:0] code, input logic shift);
    logic [7:0] ch;
    ch = 8'h00;
    if (!code[7]) begin
      if (code >= 8'h04 && code <= 8'h1D) begin
        ch = (shift ? 8'h41 : 8'h61) + (code - 8'h04);
      end else if (!shift && code >= 8'h1E && code <= 8'h26) begin
        ch = 8'h31 + (code - 8'h1E);
      end else if (!shift) begin
        case (code)
          8'h27:   ch = 8'h30;
          8'h28:   ch = 8'h0A;
          8'h2C:   ch = 8'h20;
          8'h2D:   ch = 8'h2D;
          8'h2E:   ch = 8'h3D;
          8'h2F:   ch = 8'h5B;
          8'h30:   ch = 8'h5D;
          8'h31:   ch = 8'h23;
          8'h32:   ch = 8'h5C;
          8'h33:   ch = 8'h3B;
          8'h34:   ch = 8'h27;
          8'h35:   ch = 8'h60;
          8'h36:   ch = 8'h2C;
          8'h37:   ch = 8'h2E;
          8'h38:   ch = 8'h2F;
          default: ch = 8'h00;
        endcase
      end else begin
        case (code)
          8'h1E:   ch = 8'h21;
          8'h1F:   ch = 8'h22;
          8'h20:   ch = 8'hA3;  // pound, Latin-1
          8'h21:   ch = 8'h24;
          8'h22:   ch = 8'h25;
          8'h23:   ch = 8'h5E;
          8'h24:   ch = 8'h26;
          8'h25:   ch = 8'h2A;
          8'h26:   ch = 8'h28;
          8'h27:   ch = 8'h29;
          8'h2D:   ch = 8'h5F;
          8'h2E:   ch = 8'h2B;
          8'h2F:   ch = 8'h7B;
          8'h30:   ch = 8'h7D;
          8'h31:   ch = 8'h7E;
          8'h32:   ch = 8'h7C;
          8'h33:   ch = 8'h3A;
          8'h34:   ch = 8'h40;
          8'h35:   ch = 8'hAC;  // not sign, Latin-1
          8'h36:   ch = 8'h3C;
          8'h37:   ch = 8'h3E;
          8'h38:   ch = 8'h3F;
          default: ch = 8'h00;
        endcase
      end
    end
    return ch;
  endfunction

endpackage

// ===== hdl/hkf_key_track.sv =====
module hkf_key_track (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  hkf_pkg::key_row_t              codes,
  input  logic [7:0]                     query_key,
  output logic [hkf_pkg::KEY_SLOTS-1:0]  push_mask,
  output logic                           query_hit
);

  // Keys of the last report (previous and current are always equal after a report)
  hkf_pkg::key_row_t keys;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (load) begin
      keys <= codes;
    end
  end

  // New-key detect: nonzero, not backspace, absent from the last report
  always_comb begin
    logic held;
    for (int i = 0; i < hkf_pkg::KEY_SLOTS; i++) begin
      held = 1'b0;
      for (int j = 0; j < hkf_pkg::KEY_SLOTS; j++) begin
        if (keys[j] == codes[i]) begin
          held = 1'b1;
        end
      end
      push_mask[i] = (codes[i] != 8'h00) && !held && (codes[i] != hkf_pkg::CODE_BACKSPACE);
    end
  end

  // Held-key query
  always_comb begin
    query_hit = 1'b0;
    for (int j = 0; j < hkf_pkg::KEY_SLOTS; j++) begin
      if (keys[j] == query_key && query_key != 8'h00) begin
        query_hit = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/hkf_key_fifo.sv =====
module hkf_key_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  hkf_pkg::hkf_fifo_ctl_t ctl,
  input  hkf_pkg::key_row_t     codes,
  output hkf_pkg::hkf_fifo_sts_t sts
);

  logic [7:0]                 mem [hkf_pkg::FIFO_DEPTH];
  logic [hkf_pkg::PTR_W-1:0]  wp;
  logic [hkf_pkg::PTR_W-1:0]  rp;
  logic [hkf_pkg::PTR_W-1:0]  wp_next;
  logic [hkf_pkg::PTR_W-1:0]  rp_next;
  logic [hkf_pkg::PTR_W-1:0]  fill;
  logic [hkf_pkg::PTR_W-1:0]  space;
  logic                       not_empty;

  logic [hkf_pkg::KEY_SLOTS-1:0]                          take;
  logic [hkf_pkg::KEY_SLOTS-1:0][hkf_pkg::PTR_W-1:0]      addr;
  logic [hkf_pkg::KEY_CNT_W-1:0]                          n_cand;
  logic [hkf_pkg::KEY_CNT_W-1:0]                          n_push;

  assign fill      = hkf_pkg::fill_of(wp, rp);
  assign space     = hkf_pkg::PTR_W'(hkf_pkg::FIFO_DEPTH - 1) - fill;
  assign not_empty = (fill != '0);

  // Slot-order pushes: the k-th new key lands at wp+k while room remains
  always_comb begin
    logic [hkf_pkg::CMP_W:0] sum;
    n_cand = '0;
    n_push = '0;
    for (int i = 0; i < hkf_pkg::KEY_SLOTS; i++) begin
      sum = (hkf_pkg::CMP_W+1)'(wp) + (hkf_pkg::CMP_W+1)'(n_cand);
      if (sum >= (hkf_pkg::CMP_W+1)'(hkf_pkg::FIFO_DEPTH)) begin
        sum = sum - (hkf_pkg::CMP_W+1)'(hkf_pkg::FIFO_DEPTH);
      end
      addr[i] = sum[hkf_pkg::PTR_W-1:0];
      take[i] = ctl.push_mask[i] &&
                (hkf_pkg::CMP_W'(n_cand) < hkf_pkg::CMP_W'(space));
      if (ctl.push_mask[i]) begin
        n_cand = n_cand + 1'b1;
      end
      if (take[i]) begin
        n_push = n_push + 1'b1;
      end
    end
  end

  // Pointer update
  always_comb begin
    logic [hkf_pkg::CMP_W:0] wsum;
    wsum = (hkf_pkg::CMP_W+1)'(wp) + (hkf_pkg::CMP_W+1)'(n_push);
    if (wsum >= (hkf_pkg::CMP_W+1)'(hkf_pkg::FIFO_DEPTH)) begin
      wsum = wsum - (hkf_pkg::CMP_W+1)'(hkf_pkg::FIFO_DEPTH);
    end
    wp_next = wsum[hkf_pkg::PTR_W-1:0];
    rp_next = rp;
    if (ctl.pop && not_empty) begin
      rp_next = hkf_pkg::ring_next(rp);
    end
    if (ctl.flush) begin
      wp_next = '0;
      rp_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      wp <= wp_next;
      rp <= rp_next;
    end
  end

  // Entry storage, up to six writes at distinct addresses
  always_ff @(posedge clk) begin
    for (int i = 0; i < hkf_pkg::KEY_SLOTS; i++) begin
      if (take[i]) begin
        mem[addr[i]] <= codes[i];
      end
    end
  end

  assign sts.pop_code  = not_empty ? mem[rp] : 8'h00;
  assign sts.fill_next = hkf_pkg::fill_of(wp_next, rp_next);
  assign sts.dropped   = n_cand - n_push;

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.flush |=> (wp == '0) && (rp == '0))
    else $error("flush did not clear pointers");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop && !not_empty && !ctl.flush) |=> $stable(rp) && $stable(wp))
    else $error("pop on empty moved a pointer");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (sts.dropped != '0) |-> (sts.fill_next == hkf_pkg::PTR_W'(hkf_pkg::FIFO_DEPTH - 1)))
    else $error("key dropped with room left");

endmodule

// ===== hdl/hid_keyboard_report_key_fifo_core.sv =====
// Boot-keyboard report decoder with a key FIFO and UK keymap.
//
// Request channel (req_valid/req_ready/req) carries one command per transfer:
// a report (modifiers plus six key codes), a raw or ascii pop, a flush, or a
// held-key query. Response channel (rsp_valid/rsp_ready/rsp) returns exactly
// one result per request, in order: value, fifo_count, shift_held, dropped.
//
// A request is taken into the input register, then decoded, key-compared and
// applied to the FIFO on its way into the response register, which drives
// rsp. Throughput: one request per cycle while responses are taken, limited by
// the single decode stage that reads and updates the FIFO pointers.
//
// When rsp_ready is low the response register holds; one more request can
// still be taken into the input register, after which req_ready drops until
// the response is taken.
//
// Reset (rst, synchronous) empties the FIFO, clears the stored keys and the
// shift flag, and drops any request or response in flight.
module hid_keyboard_report_key_fifo_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  hkf_pkg::hkf_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output hkf_pkg::hkf_rsp_t rsp
);

  hkf_pkg::hkf_req_t      req_q;
  logic                   req_q_valid;
  logic                   advance;
  hkf_pkg::cmd_t          cmd;
  logic                   shift;
  logic                   shift_next;
  hkf_pkg::key_row_t      codes;
  logic [hkf_pkg::KEY_SLOTS-1:0] push_mask;
  logic                   query_hit;
  hkf_pkg::hkf_fifo_ctl_t fifo_ctl;
  hkf_pkg::hkf_fifo_sts_t fifo_sts;
  hkf_pkg::hkf_rsp_t      rsp_next;

  assign advance   = req_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !req_q_valid || advance;
  assign cmd       = hkf_pkg::cmd_t'(req_q.cmd);
  assign codes     = {req_q.key_f, req_q.key_e, req_q.key_d,
                      req_q.key_c, req_q.key_b, req_q.key_a};

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  hkf_key_track u_track (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && cmd == hkf_pkg::CMD_REPORT),
    .codes     (codes),
    .query_key (req_q.query_key),
    .push_mask (push_mask),
    .query_hit (query_hit)
  );

  // Command decode into FIFO control
  always_comb begin
    fifo_ctl = '0;
    if (advance) begin
      case (cmd)
        hkf_pkg::CMD_REPORT:    fifo_ctl.push_mask = push_mask;
        hkf_pkg::CMD_POP_RAW:   fifo_ctl.pop = 1'b1;
        hkf_pkg::CMD_POP_ASCII: fifo_ctl.pop = 1'b1;
        hkf_pkg::CMD_FLUSH:     fifo_ctl.flush = 1'b1;
        default:                fifo_ctl = '0;
      endcase
    end
  end

  hkf_key_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fifo_ctl),
    .codes (codes),
    .sts   (fifo_sts)
  );

  // Shift flag and result value
  always_comb begin
    shift_next        = shift;
    rsp_next.value    = 8'h00;
    rsp_next.dropped  = 3'd0;
    case (cmd)
      hkf_pkg::CMD_REPORT: begin
        shift_next = req_q.modifiers[hkf_pkg::SHIFT_LEFT_BIT] ||
                     req_q.modifiers[hkf_pkg::SHIFT_RIGHT_BIT];
        rsp_next.dropped = 3'(fifo_sts.dropped);
      end
      hkf_pkg::CMD_POP_RAW:   rsp_next.value = fifo_sts.pop_code;
      hkf_pkg::CMD_POP_ASCII: rsp_next.value = hkf_pkg::map_code(fifo_sts.pop_code, shift);
      hkf_pkg::CMD_FLUSH:     shift_next = 1'b0;
      hkf_pkg::CMD_QUERY:     rsp_next.value = query_hit ? req_q.query_key : 8'h00;
      default:                rsp_next.value = 8'h00;
    endcase
    rsp_next.fifo_count = 3'(fifo_sts.fill_next);
    rsp_next.shift_held = shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= 1'b0;
    end else if (advance) begin
      shift <= shift_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  a_advance_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("decoded request produced no response");

endmodule

// ===== tb/sv/tb_hid_keyboard_report_key_fifo_core.sv =====
`timescale 1ns / 1ps

module tb_hid_keyboard_report_key_fifo_core;

  localparam int          RANDOM_ITEMS    = 430;
  localparam int          HOLD_OFF_CYCLES = 120;
  localparam int          STALL_LIMIT     = 1000;
  localparam int          TAIL_CYCLES     = 8;
  localparam int          REPORT_LIMIT    = 10;
  localparam logic [2:0]  CMD_SPARE_LO    = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI    = 3'd7;

  // Tracks decoder state, predicts each response and checks it in order
  class key_fifo_scoreboard;
    logic [7:0]                ring [hkf_pkg::FIFO_DEPTH];
    logic [hkf_pkg::PTR_W-1:0] wr_ptr;
    logic [hkf_pkg::PTR_W-1:0] rd_ptr;
    hkf_pkg::key_row_t         prev_row;
    hkf_pkg::key_row_t         now_row;
    logic                      shift_on;
    logic [7:0]                plain_map [128];
    logic [7:0]                upper_map [128];
    hkf_pkg::hkf_rsp_t         awaited_rsp [$];
    int faults, checked, reports, pops, queries, flushes, drops, full_hits;

    function new();
      string lo_row, hi_row, lo_punct, hi_punct;
      int i;
      // letters and digit row start at 0x04, punctuation at 0x2D
      lo_row   = "abcdefghijklmnopqrstuvwxyz1234567890";
      hi_row   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ!\"#$%^&*()";
      lo_punct = "-=[]#\\;'`,./";
      hi_punct = "_+{}~|:@#<>?";
      for (i = 0; i < 128; i++) begin
        plain_map[i] = 8'h00;
        upper_map[i] = 8'h00;
      end
      for (i = 0; i < 36; i++) begin
        plain_map[8'h04 + i] = lo_row[i];
        upper_map[8'h04 + i] = hi_row[i];
      end
      for (i = 0; i < 12; i++) begin
        plain_map[8'h2D + i] = lo_punct[i];
        upper_map[8'h2D + i] = hi_punct[i];
      end
      plain_map[8'h28] = 8'h0A;
      plain_map[8'h2C] = 8'h20;
      // pound and not sign are Latin-1
      upper_map[8'h20] = 8'hA3;
      upper_map[8'h35] = 8'hAC;
      wr_ptr   = '0;
      rd_ptr   = '0;
      prev_row = '0;
      now_row  = '0;
      shift_on = 1'b0;
      foreach (ring[k]) ring[k] = 8'h00;
      faults = 0; checked = 0; reports = 0; pops = 0;
      queries = 0; flushes = 0; drops = 0; full_hits = 0;
    endfunction

    function logic [hkf_pkg::PTR_W-1:0] ptr_after(input logic [hkf_pkg::PTR_W-1:0] p);
      return hkf_pkg::PTR_W'((int'(p) + 1) % hkf_pkg::FIFO_DEPTH);
    endfunction

    function logic [7:0] take_oldest();
      logic [7:0] code;
      if (rd_ptr == wr_ptr) begin
        return 8'h00;
      end
      code   = ring[rd_ptr];
      rd_ptr = ptr_after(rd_ptr);
      return code;
    endfunction

    // One decoder step: updates state, returns the response it causes
    function hkf_pkg::hkf_rsp_t decode_step(input hkf_pkg::hkf_req_t r);
      hkf_pkg::hkf_rsp_t         res;
      logic [7:0]                code;
      logic [hkf_pkg::PTR_W-1:0] nxt;
      logic                      seen;
      int                        s, p, fill;
      res = '0;
      case (r.cmd)
        hkf_pkg::CMD_REPORT: begin
          reports++;
          shift_on = r.modifiers[hkf_pkg::SHIFT_LEFT_BIT] |
                     r.modifiers[hkf_pkg::SHIFT_RIGHT_BIT];
          // slot 0 sits in the low byte
          now_row = {r.key_f, r.key_e, r.key_d, r.key_c, r.key_b, r.key_a};
          for (s = 0; s < hkf_pkg::KEY_SLOTS; s++) begin
            code = now_row[s];
            seen = 1'b0;
            for (p = 0; p < hkf_pkg::KEY_SLOTS; p++) begin
              if (prev_row[p] == code) seen = 1'b1;
            end
            if (code != 8'h00 && !seen && code != hkf_pkg::CODE_BACKSPACE) begin
              nxt = ptr_after(wr_ptr);
              if (nxt == rd_ptr) begin
                res.dropped = res.dropped + 3'd1;
              end else begin
                ring[wr_ptr] = code;
                wr_ptr       = nxt;
              end
            end
          end
          prev_row = now_row;
          drops += res.dropped;
        end
        hkf_pkg::CMD_POP_RAW: begin
          pops++;
          res.value = take_oldest();
        end
        hkf_pkg::CMD_POP_ASCII: begin
          pops++;
          code = take_oldest();
          if (!code[7]) begin
            res.value = shift_on ? upper_map[code[6:0]] : plain_map[code[6:0]];
          end
        end
        hkf_pkg::CMD_FLUSH: begin
          flushes++;
          wr_ptr   = '0;
          rd_ptr   = '0;
          shift_on = 1'b0;
        end
        hkf_pkg::CMD_QUERY: begin
          queries++;
          if (r.query_key != 8'h00) begin
            for (s = 0; s < hkf_pkg::KEY_SLOTS; s++) begin
              if (now_row[s] == r.query_key) res.value = r.query_key;
            end
          end
        end
        default: ;
      endcase
      fill = (int'(wr_ptr) + hkf_pkg::FIFO_DEPTH - int'(rd_ptr)) % hkf_pkg::FIFO_DEPTH;
      if (fill == hkf_pkg::FIFO_DEPTH - 1) full_hits++;
      res.fifo_count = 3'(fill);
      res.shift_held = shift_on;
      return res;
    endfunction

    function void note_request(input hkf_pkg::hkf_req_t r);
      awaited_rsp.push_back(decode_step(r));
    endfunction

    function void check_response(input hkf_pkg::hkf_rsp_t got);
      hkf_pkg::hkf_rsp_t want;
      checked++;
      if (awaited_rsp.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("response %0d: none awaited, got value %02h count %0d shift %0b dropped %0d",
                   checked, got.value, got.fifo_count, got.shift_held, got.dropped);
        end
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.value !== want.value || got.fifo_count !== want.fifo_count ||
          got.shift_held !== want.shift_held || got.dropped !== want.dropped) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("response %0d: expected value %02h count %0d shift %0b dropped %0d",
                   checked, want.value, want.fifo_count, want.shift_held, want.dropped);
          $display("response %0d:   actual value %02h count %0d shift %0b dropped %0d",
                   checked, got.value, got.fifo_count, got.shift_held, got.dropped);
        end
      end
    endfunction

    function int outstanding();
      return awaited_rsp.size();
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  hkf_pkg::hkf_req_t req       = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  hkf_pkg::hkf_rsp_t rsp;

  key_fifo_scoreboard sb;
  hkf_pkg::key_row_t  sent_row = '0;
  bit                 send_calm = 1'b0;
  int                 quiet_cycles = 0;

  hid_keyboard_report_key_fifo_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Observe transfers on both channels; watchdog on idle stretches
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                 quiet_cycles, sb.outstanding());
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic hkf_pkg::hkf_req_t noise_request();
    hkf_pkg::hkf_req_t item;
    item.cmd       = 3'($urandom_range(0, 7));
    item.modifiers = 8'($urandom_range(0, 255));
    item.key_a     = 8'($urandom_range(0, 255));
    item.key_b     = 8'($urandom_range(0, 255));
    item.key_c     = 8'($urandom_range(0, 255));
    item.key_d     = 8'($urandom_range(0, 255));
    item.key_e     = 8'($urandom_range(0, 255));
    item.key_f     = 8'($urandom_range(0, 255));
    item.query_key = 8'($urandom_range(0, 255));
    return item;
  endfunction

  // Offer one request; valid stays up across back-to-back transfers
  task automatic send_item(input hkf_pkg::hkf_req_t item);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_report(input logic [7:0] mods, input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
                             input logic [7:0] f);
    hkf_pkg::hkf_req_t item;
    item           = noise_request();
    item.cmd       = hkf_pkg::CMD_REPORT;
    item.modifiers = mods;
    item.key_a     = a;
    item.key_b     = b;
    item.key_c     = c;
    item.key_d     = d;
    item.key_e     = e;
    item.key_f     = f;
    sent_row       = {f, e, d, c, b, a};
    send_item(item);
  endtask

  task automatic send_command(input logic [2:0] op, input logic [7:0] look_for);
    hkf_pkg::hkf_req_t item;
    item           = noise_request();
    item.cmd       = op;
    item.query_key = look_for;
    send_item(item);
  endtask

  // Key code for one slot: often a key still held from the last report
  function automatic logic [7:0] pick_code();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return sent_row[$urandom_range(0, hkf_pkg::KEY_SLOTS - 1)];
    if (roll < 60) return 8'h00;
    if (roll < 65) return hkf_pkg::CODE_BACKSPACE;
    if (roll < 90) return 8'($urandom_range(8'h04, 8'h38));
    return 8'($urandom_range(0, 255));
  endfunction

  // Response side: random stalls, calm stretches, two long hold-offs
  task automatic drain_responses();
    int  stall, served;
    bit  calm;
    served = 0;
    calm   = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      if (served == 80 || served == 300) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = calm ? 0 : $urandom_range(0, 15);
        if (stall > 0) begin
          rsp_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      served++;
    end
  endtask

  initial begin
    int n, roll;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_responses();
    join_none

    // directed: query for code zero, duplicates, backspace, held keys
    send_command(hkf_pkg::CMD_QUERY, 8'h00);
    send_report(8'h02, 8'h04, 8'h05, hkf_pkg::CODE_BACKSPACE, 8'h00, 8'h04, 8'hFF);
    send_report(8'h00, 8'h04, 8'h05, hkf_pkg::CODE_BACKSPACE, 8'h00, 8'h04, 8'hFF);
    send_command(hkf_pkg::CMD_QUERY, 8'h05);
    send_command(hkf_pkg::CMD_QUERY, 8'hFF);
    send_report(8'h02, 8'h04, 8'h05, hkf_pkg::CODE_BACKSPACE, 8'h00, 8'h04, 8'hFF);
    send_command(hkf_pkg::CMD_POP_ASCII, 8'h00);
    // fill up, then a report of six new keys while full
    send_report(8'h20, 8'h20, 8'h35, 8'h1E, 8'h38, 8'h80, 8'h7F);
    send_report(8'hDD, 8'h01, 8'h02, 8'h03, 8'h06, 8'h07, 8'h08);
    send_command(hkf_pkg::CMD_POP_RAW, 8'h00);
    send_command(hkf_pkg::CMD_POP_ASCII, 8'h00);
    send_command(hkf_pkg::CMD_POP_ASCII, 8'h00);
    // shifted map: pound, not sign, digit row, punctuation
    send_report(8'h22, 8'h01, 8'h02, 8'h03, 8'h06, 8'h07, 8'h08);
    repeat (4) send_command(hkf_pkg::CMD_POP_ASCII, 8'h00);
    // pops on an empty queue
    send_command(hkf_pkg::CMD_POP_RAW, 8'h00);
    send_command(hkf_pkg::CMD_POP_ASCII, 8'h00);
    send_command(hkf_pkg::CMD_FLUSH, 8'h00);
    send_command(CMD_SPARE_LO, 8'h08);
    send_command(CMD_SPARE_HI, 8'hFF);
    send_command(hkf_pkg::CMD_QUERY, 8'h08);
    send_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_command(hkf_pkg::CMD_FLUSH, 8'h00);

    // random: mostly plausible report streams with pops in between
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 36) begin
        send_report(8'($urandom_range(0, 255)), pick_code(), pick_code(), pick_code(),
                    pick_code(), pick_code(), pick_code());
      end else if (roll < 56) begin
        send_command(hkf_pkg::CMD_POP_RAW, 8'($urandom_range(0, 255)));
      end else if (roll < 80) begin
        send_command(hkf_pkg::CMD_POP_ASCII, 8'($urandom_range(0, 255)));
      end else if (roll < 92) begin
        if ($urandom_range(0, 9) < 6) begin
          send_command(hkf_pkg::CMD_QUERY,
                       sent_row[$urandom_range(0, hkf_pkg::KEY_SLOTS - 1)]);
        end else begin
          send_command(hkf_pkg::CMD_QUERY, 8'($urandom_range(0, 255)));
        end
      end else if (roll < 96) begin
        send_command(hkf_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
      end else begin
        send_command(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                     8'($urandom_range(0, 255)));
      end
    end
    req_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d reports (%0d keys dropped, queue full %0d times),",
             sb.reports, sb.drops, sb.full_hits);
    $display("  %0d pops, %0d queries, %0d flushes; %0d responses checked, %0d mismatches",
             sb.pops, sb.queries, sb.flushes, sb.checked, sb.faults);
    if (sb.faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hkf_pkg.sv
hdl/hkf_key_track.sv
hdl/hkf_key_fifo.sv
hdl/hid_keyboard_report_key_fifo_core.sv
tb/sv/tb_hid_keyboard_report_key_fifo_core.sv
